/* rtl/core/fraction_arith_reduce_macros.svh */
// Assertion macros shared by the fraction block.
`ifndef FRACTION_ARITH_REDUCE_MACROS_SVH
`define FRACTION_ARITH_REDUCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fraction_arith_reduce: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fraction_arith_reduce: next-cycle check failed");

`endif

/* rtl/core/far_pkg.sv */
`default_nettype none

package far_pkg;

  localparam int FIELD_W   = 16;
  localparam int FUNC_W    = 3;
  localparam int NUM_W     = 33;
  localparam int DEN_W     = 32;
  localparam int PROD_W    = 2 * FIELD_W;
  localparam int K_W       = 5;
  localparam int CNT_W     = 6;
  localparam int DIV_STEPS = NUM_W;

  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INC = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RED = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_EQ  = 3'd4;

  typedef enum logic [2:0] {
    T_IDLE,
    T_MUL_A,
    T_MUL_B,
    T_MUL_C,
    T_MUL_D,
    T_CHECK,
    T_WAIT,
    T_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_GCD,
    R_DIVN,
    R_DIVD,
    R_DONE
  } red_state_t;

  typedef struct packed {
    logic start;
  } red_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } red_stat_t;

endpackage

`default_nettype wire

/* rtl/core/fraction_arith_reduce.sv */
`default_nettype none

// Channel  Handshake              Fields
// input    in_valid / in_stall    func, a_num, a_den, b_num, b_den
// output   out_valid / out_stall  res_num, res_den, is_equal
//
// Equal and unused codes go straight to the output state; an add, increment or
// reduce passes the check state first. Multiply and cross add first use one shared
// 16 by 16 multiplier. A reducible result runs a binary GCD on one shared 33-bit
// subtractor, then two 33-step restoring divisions on that subtractor.
// Synchronous reset clears only control state; in_stall stays high from an accepted word
// until its result sits in the output register, which holds while out_stall is high.

`include "fraction_arith_reduce_macros.svh"

module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [far_pkg::FUNC_W-1:0]  func,
  input  wire logic [far_pkg::FIELD_W-1:0] a_num,
  input  wire logic [far_pkg::FIELD_W-1:0] a_den,
  input  wire logic [far_pkg::FIELD_W-1:0] b_num,
  input  wire logic [far_pkg::FIELD_W-1:0] b_den,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [far_pkg::NUM_W-1:0]        res_num,
  output logic [far_pkg::DEN_W-1:0]        res_den,
  output logic                             is_equal
);

  localparam int FW = far_pkg::FIELD_W;
  localparam int NW = far_pkg::NUM_W;
  localparam int DW = far_pkg::DEN_W;
  localparam int PW = far_pkg::PROD_W;
  localparam logic [FW-1:0] OP_MASK = (OPERAND_WIDTH >= FW) ? {FW{1'b1}}
                                      : FW'((64'd1 << OPERAND_WIDTH) - 64'd1);

  far_pkg::top_state_t state;
  far_pkg::top_state_t state_next;

  logic [far_pkg::FUNC_W-1:0] fn;
  logic [FW-1:0] an;
  logic [FW-1:0] ad;
  logic [FW-1:0] bn;
  logic [FW-1:0] bd;
  logic [NW-1:0] n;
  logic [DW-1:0] d;
  logic          eq;
  logic [PW-1:0] p;

  logic [FW-1:0] an_in;
  logic [FW-1:0] ad_in;
  logic [FW-1:0] bn_in;
  logic [FW-1:0] bd_in;
  logic [FW-1:0] mul_x;
  logic [FW-1:0] mul_y;
  logic [PW-1:0] prod;
  logic          load_out;
  logic          reducible;

  far_pkg::red_ctrl_t red_ctrl;
  far_pkg::red_stat_t red_stat;
  logic [NW-1:0]      red_num;
  logic [DW-1:0]      red_den;

  assign an_in     = a_num & OP_MASK;
  assign ad_in     = a_den & OP_MASK;
  assign bn_in     = b_num & OP_MASK;
  assign bd_in     = b_den & OP_MASK;
  assign prod      = PW'(mul_x) * PW'(mul_y);
  assign reducible = (n != '0) && (d != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      far_pkg::T_IDLE: begin
        if (in_valid) begin
          priority if (func == far_pkg::FUNC_ADD && ad_in != bd_in) begin
            state_next = far_pkg::T_MUL_A;
          end else if (func == far_pkg::FUNC_MUL) begin
            state_next = far_pkg::T_MUL_A;
          end else if (func == far_pkg::FUNC_ADD || func == far_pkg::FUNC_INC ||
                       func == far_pkg::FUNC_RED) begin
            state_next = far_pkg::T_CHECK;
          end else begin
            state_next = far_pkg::T_OUT;
          end
        end
      end
      far_pkg::T_MUL_A: state_next = far_pkg::T_MUL_B;
      far_pkg::T_MUL_B: state_next = far_pkg::T_MUL_C;
      far_pkg::T_MUL_C: begin
        state_next = (fn == far_pkg::FUNC_ADD) ? far_pkg::T_MUL_D : far_pkg::T_CHECK;
      end
      far_pkg::T_MUL_D: state_next = far_pkg::T_CHECK;
      far_pkg::T_CHECK: begin
        state_next = reducible ? far_pkg::T_WAIT : far_pkg::T_OUT;
      end
      far_pkg::T_WAIT: begin
        if (red_stat.done) begin
          state_next = far_pkg::T_OUT;
        end
      end
      far_pkg::T_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = far_pkg::T_IDLE;
        end
      end
      default: state_next = far_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != far_pkg::T_IDLE);
    red_ctrl.start = (state == far_pkg::T_CHECK) && reducible;
    load_out       = (state == far_pkg::T_OUT) && (!out_valid || !out_stall);
    unique case (state)
      far_pkg::T_MUL_A: begin
        mul_x = an;
        mul_y = (fn == far_pkg::FUNC_ADD) ? bd : bn;
      end
      far_pkg::T_MUL_B: begin
        mul_x = (fn == far_pkg::FUNC_ADD) ? bn : ad;
        mul_y = (fn == far_pkg::FUNC_ADD) ? ad : bd;
      end
      far_pkg::T_MUL_C: begin
        mul_x = ad;
        mul_y = bd;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= far_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    p <= prod;
    unique case (state)
      far_pkg::T_IDLE: begin
        if (in_valid) begin
          fn <= func;
          an <= an_in;
          ad <= ad_in;
          bn <= bn_in;
          bd <= bd_in;
          eq <= 1'b0;
          unique case (func)
            far_pkg::FUNC_ADD: begin
              n <= NW'(an_in) + NW'(bn_in);
              d <= DW'(ad_in);
            end
            far_pkg::FUNC_INC: begin
              n <= NW'(an_in) + NW'(ad_in);
              d <= DW'(ad_in);
            end
            far_pkg::FUNC_RED: begin
              n <= NW'(an_in);
              d <= DW'(ad_in);
            end
            far_pkg::FUNC_EQ: begin
              n  <= '0;
              d  <= '0;
              eq <= (an_in == bn_in) && (ad_in == bd_in);
            end
            default: begin
              n <= '0;
              d <= '0;
            end
          endcase
        end
      end
      far_pkg::T_MUL_B: n <= NW'(p);
      far_pkg::T_MUL_C: begin
        if (fn == far_pkg::FUNC_ADD) begin
          n <= n + NW'(p);
        end else begin
          d <= DW'(p);
        end
      end
      far_pkg::T_MUL_D: d <= DW'(p);
      far_pkg::T_WAIT: begin
        if (red_stat.done) begin
          n <= red_num;
          d <= red_den;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_num  <= n;
      res_den  <= d;
      is_equal <= eq;
    end
  end

  far_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (red_ctrl),
    .num_in  (n),
    .den_in  (d),
    .stat    (red_stat),
    .num_out (red_num),
    .den_out (red_den)
  );

  `FAR_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `FAR_ASSERT_NOW(a_equal_zero_result, clk, rst, out_valid && is_equal, res_num == '0 && res_den == '0)
  `FAR_ASSERT_NOW(a_idle_reducer_free, clk, rst, !in_stall, !red_stat.busy)
  `FAR_ASSERT_NOW(a_result_reopens_input, clk, rst, $rose(out_valid), !in_stall)

endmodule

`default_nettype wire

/* rtl/core/far_reduce.sv */
`default_nettype none

module far_reduce (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire far_pkg::red_ctrl_t        ctrl,
  input  wire logic [far_pkg::NUM_W-1:0] num_in,
  input  wire logic [far_pkg::DEN_W-1:0] den_in,
  output far_pkg::red_stat_t             stat,
  output logic [far_pkg::NUM_W-1:0]      num_out,
  output logic [far_pkg::DEN_W-1:0]      den_out
);

  localparam int NW = far_pkg::NUM_W;
  localparam int DW = far_pkg::DEN_W;
  localparam int CW = far_pkg::CNT_W;
  localparam logic [CW-1:0] LAST = CW'(far_pkg::DIV_STEPS - 1);

  far_pkg::red_state_t state;
  far_pkg::red_state_t state_next;

  logic [NW-1:0]              x;
  logic [NW-1:0]              y;
  logic [far_pkg::K_W-1:0]    k;
  logic [NW-1:0]              g;
  logic [NW-1:0]              rem;
  logic [NW-1:0]              quo;
  logic [CW-1:0]              cnt;
  logic [NW-1:0]              nn;
  logic [DW-1:0]              dd;

  logic [NW-1:0] sub_a;
  logic [NW-1:0] sub_b;
  logic [NW:0]   diff;
  logic          borrow;
  logic [NW-1:0] rem_sh;
  logic [NW-1:0] rem_step;
  logic [NW-1:0] quo_step;

  // One subtractor serves both the binary GCD and the restoring divisions.
  assign rem_sh = {rem[NW-2:0], quo[NW-1]};

  always_comb begin
    unique case (state)
      far_pkg::R_GCD: begin
        sub_a = x;
        sub_b = y;
      end
      far_pkg::R_DIVN, far_pkg::R_DIVD: begin
        sub_a = rem_sh;
        sub_b = g;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = diff[NW];
  assign rem_step = borrow ? rem_sh : diff[NW-1:0];
  assign quo_step = {quo[NW-2:0], ~borrow};

  always_comb begin
    state_next = state;
    unique case (state)
      far_pkg::R_IDLE: begin
        if (ctrl.start) begin
          state_next = far_pkg::R_GCD;
        end
      end
      far_pkg::R_GCD: begin
        if (x == y) begin
          state_next = far_pkg::R_DIVN;
        end
      end
      far_pkg::R_DIVN: begin
        if (cnt == LAST) begin
          state_next = far_pkg::R_DIVD;
        end
      end
      far_pkg::R_DIVD: begin
        if (cnt == LAST) begin
          state_next = far_pkg::R_DONE;
        end
      end
      default: begin
        state_next = far_pkg::R_IDLE;
      end
    endcase
  end

  always_comb begin
    stat.busy = (state != far_pkg::R_IDLE);
    stat.done = (state == far_pkg::R_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= far_pkg::R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      far_pkg::R_IDLE: begin
        if (ctrl.start) begin
          x  <= num_in;
          y  <= {1'b0, den_in};
          nn <= num_in;
          dd <= den_in;
          k  <= '0;
        end
      end
      far_pkg::R_GCD: begin
        priority if (x == y) begin
          g   <= x << k;
          rem <= '0;
          quo <= nn;
          cnt <= '0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (borrow) begin
          x <= y;
          y <= x;
        end else begin
          x <= diff[NW-1:0];
        end
      end
      far_pkg::R_DIVN: begin
        if (cnt == LAST) begin
          num_out <= quo_step;
          rem     <= '0;
          quo     <= {1'b0, dd};
          cnt     <= '0;
        end else begin
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt + 1'b1;
        end
      end
      far_pkg::R_DIVD: begin
        rem <= rem_step;
        quo <= quo_step;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          den_out <= quo_step[DW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* bench/fraction_arith_reduce_checker.sv */
`timescale 1ns / 100ps

module fraction_arith_reduce_checker #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [far_pkg::FUNC_W-1:0]  func,
  input  logic [far_pkg::FIELD_W-1:0] a_num,
  input  logic [far_pkg::FIELD_W-1:0] a_den,
  input  logic [far_pkg::FIELD_W-1:0] b_num,
  input  logic [far_pkg::FIELD_W-1:0] b_den,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [far_pkg::NUM_W-1:0]   res_num,
  input  logic [far_pkg::DEN_W-1:0]   res_den,
  input  logic                        is_equal,
  output int                          mismatch_count,
  output int                          outstanding
);

  typedef struct packed {
    logic [far_pkg::NUM_W-1:0] num;
    logic [far_pkg::DEN_W-1:0] den;
    logic                      eq;
  } fraction_t;

  fraction_t pending_fractions[$];

  function automatic fraction_t evaluate_fraction(
    input logic [far_pkg::FUNC_W-1:0]  op,
    input logic [far_pkg::FIELD_W-1:0] an_in,
    input logic [far_pkg::FIELD_W-1:0] ad_in,
    input logic [far_pkg::FIELD_W-1:0] bn_in,
    input logic [far_pkg::FIELD_W-1:0] bd_in
  );
    logic [63:0] mask;
    logic [63:0] an, ad, bn, bd;
    logic [63:0] n, d, x, y, r;
    bit          simplify;
    fraction_t   res;
    mask = ((64'd1 << OPERAND_WIDTH) - 64'd1) & ((64'd1 << far_pkg::FIELD_W) - 64'd1);
    an = 64'(an_in) & mask;
    ad = 64'(ad_in) & mask;
    bn = 64'(bn_in) & mask;
    bd = 64'(bd_in) & mask;
    n = '0;
    d = '0;
    res.eq = 1'b0;
    simplify = 1'b1;
    case (op)
      far_pkg::FUNC_ADD: begin
        if (ad == bd) begin
          n = an + bn;
          d = ad;
        end else begin
          n = an * bd + bn * ad;
          d = ad * bd;
        end
      end
      far_pkg::FUNC_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      far_pkg::FUNC_INC: begin
        n = an + ad;
        d = ad;
      end
      far_pkg::FUNC_RED: begin
        n = an;
        d = ad;
      end
      far_pkg::FUNC_EQ: begin
        res.eq = (an == bn) && (ad == bd);
        simplify = 1'b0;
      end
      default: begin
        simplify = 1'b0;
      end
    endcase
    n &= (64'd1 << far_pkg::NUM_W) - 64'd1;
    d &= (64'd1 << far_pkg::DEN_W) - 64'd1;
    if (simplify && n != 0 && d != 0) begin
      x = n;
      y = d;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      n = n / x;
      d = d / x;
    end
    res.num = n[far_pkg::NUM_W-1:0];
    res.den = d[far_pkg::DEN_W-1:0];
    return res;
  endfunction

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    fraction_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_fractions.size() == 0) begin
          $display("%0t: unexpected result word num %0d den %0d eq %0b",
                   $time, res_num, res_den, is_equal);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = pending_fractions.pop_front();
          if (res_num !== want.num || res_den !== want.den || is_equal !== want.eq) begin
            $display("%0t: expected num %0d den %0d eq %0b, got num %0d den %0d eq %0b",
                     $time, want.num, want.den, want.eq, res_num, res_den, is_equal);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_fractions.push_back(evaluate_fraction(func, a_num, a_den, b_num, b_den));
      end
    end
    outstanding = pending_fractions.size();
  end

endmodule

/* bench/tb_fraction_arith_reduce.sv */
`timescale 1ns / 100ps

module tb_fraction_arith_reduce;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PHASE_WORDS  = 325;
  localparam int SETTLE_WAIT  = 300;
  localparam int FUNC_LAST    = (1 << far_pkg::FUNC_W) - 1;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [far_pkg::FUNC_W-1:0]  func = far_pkg::FUNC_ADD;
  logic [far_pkg::FIELD_W-1:0] a_num = '0;
  logic [far_pkg::FIELD_W-1:0] a_den = '0;
  logic [far_pkg::FIELD_W-1:0] b_num = '0;
  logic [far_pkg::FIELD_W-1:0] b_den = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [far_pkg::NUM_W-1:0]   res_num;
  logic [far_pkg::DEN_W-1:0]   res_den;
  logic                        is_equal;

  int mismatch_count;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  fraction_arith_reduce i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .a_num     (a_num),
    .a_den     (a_den),
    .b_num     (b_num),
    .b_den     (b_den),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_num   (res_num),
    .res_den   (res_den),
    .is_equal  (is_equal)
  );

  fraction_arith_reduce_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .a_num          (a_num),
    .a_den          (a_den),
    .b_num          (b_num),
    .b_den          (b_den),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .res_num        (res_num),
    .res_den        (res_den),
    .is_equal       (is_equal),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[fraction_arith_reduce] ERROR");
      $finish;
    end
  end

  task automatic send_word(
    input logic [far_pkg::FUNC_W-1:0]  f,
    input logic [far_pkg::FIELD_W-1:0] an,
    input logic [far_pkg::FIELD_W-1:0] ad,
    input logic [far_pkg::FIELD_W-1:0] bn,
    input logic [far_pkg::FIELD_W-1:0] bd
  );
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [far_pkg::FIELD_W-1:0] pick_operand(input int factor, input bit is_den);
    logic [far_pkg::FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 9: v = far_pkg::FIELD_W'($urandom);
      2, 3:    v = far_pkg::FIELD_W'($urandom_range(0, 15));
      4, 5, 6: v = far_pkg::FIELD_W'(factor * $urandom_range(0, 65535 / factor));
      7:       v = $urandom_range(0, 1) ? '1 : far_pkg::FIELD_W'(1);
      default: v = far_pkg::FIELD_W'(1) << $urandom_range(0, far_pkg::FIELD_W - 1);
    endcase
    if (is_den && v == 0 && $urandom_range(0, 9) != 0) v = far_pkg::FIELD_W'(1);
    return v;
  endfunction

  task automatic send_random_word();
    logic [far_pkg::FUNC_W-1:0]  f;
    logic [far_pkg::FIELD_W-1:0] an, ad, bn, bd;
    int                          factor;
    if ($urandom_range(0, 19) == 0)
      f = far_pkg::FUNC_W'($urandom_range(far_pkg::FUNC_EQ + 1, FUNC_LAST));
    else
      f = far_pkg::FUNC_W'($urandom_range(0, far_pkg::FUNC_EQ));
    factor = $urandom_range(1, 255);
    an = pick_operand(factor, 1'b0);
    ad = pick_operand(factor, 1'b1);
    bn = pick_operand(factor, 1'b0);
    bd = pick_operand(factor, 1'b1);
    if (f == far_pkg::FUNC_ADD && $urandom_range(0, 2) == 0) bd = ad;
    if (f == far_pkg::FUNC_EQ) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          bn = an;
          bd = ad;
        end
        2: bn = an;
        default: bd = ad;
      endcase
    end
    send_word(f, an, ad, bn, bd);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send_word(far_pkg::FUNC_ADD, 16'd3, 16'd8, 16'd1, 16'd8);
    send_word(far_pkg::FUNC_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_word(far_pkg::FUNC_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_word(far_pkg::FUNC_ADD, 16'd0, 16'd5, 16'd0, 16'd7);
    send_word(far_pkg::FUNC_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(far_pkg::FUNC_MUL, 16'd0, 16'd9, 16'd5, 16'd3);
    send_word(far_pkg::FUNC_MUL, 16'd6, 16'd4, 16'd10, 16'd15);
    send_word(far_pkg::FUNC_INC, 16'd0, 16'd1, 16'd0, 16'd0);
    send_word(far_pkg::FUNC_INC, 16'hFFFF, 16'hFFFF, 16'd7, 16'd9);
    send_word(far_pkg::FUNC_INC, 16'd5, 16'd10, 16'd0, 16'd1);
    send_word(far_pkg::FUNC_RED, 16'd12, 16'd18, 16'd0, 16'd1);
    send_word(far_pkg::FUNC_RED, 16'd0, 16'd7, 16'd3, 16'd3);
    send_word(far_pkg::FUNC_RED, 16'hFFFF, 16'd1, 16'd0, 16'd1);
    send_word(far_pkg::FUNC_RED, 16'd1, 16'hFFFF, 16'd0, 16'd1);
    send_word(far_pkg::FUNC_RED, 16'h8000, 16'h4000, 16'd0, 16'd1);
    send_word(far_pkg::FUNC_EQ, 16'd17, 16'd23, 16'd17, 16'd23);
    send_word(far_pkg::FUNC_EQ, 16'd17, 16'd23, 16'd18, 16'd23);
    send_word(far_pkg::FUNC_EQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_word(far_pkg::FUNC_RED, 16'd5, 16'd0, 16'd0, 16'd1);
    send_word(far_pkg::FUNC_ADD, 16'd5, 16'd0, 16'd3, 16'd0);
    send_word(far_pkg::FUNC_MUL, 16'd4, 16'd6, 16'd2, 16'd0);
    send_word(far_pkg::FUNC_INC, 16'd9, 16'd0, 16'd0, 16'd1);
    for (int f = far_pkg::FUNC_EQ + 1; f <= FUNC_LAST; f++) begin
      send_word(far_pkg::FUNC_W'(f), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 50;
        end
        default: begin
          idle_pct = 19;
          stall_pct = 19;
        end
      endcase
      repeat (PHASE_WORDS) send_random_word();
      drain_results();
    end

    stall_pct = 0;
    repeat (SETTLE_WAIT) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("[fraction_arith_reduce] OK");
    end else begin
      $display("[fraction_arith_reduce] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/far_pkg.sv
rtl/core/far_reduce.sv
rtl/core/fraction_arith_reduce.sv
bench/fraction_arith_reduce_checker.sv
bench/tb_fraction_arith_reduce.sv
